### hw/rtl/csvt_pkg.sv
// shared constants and types for the csv record tokenizer
`timescale 1ns / 1ps
`default_nettype none
package csvt_pkg;

   // character codes
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // byte classes
   localparam logic [2:0] CLS_OTHER = 3'd0;
   localparam logic [2:0] CLS_COMMA = 3'd1;
   localparam logic [2:0] CLS_QUOTE = 3'd2;
   localparam logic [2:0] CLS_CR    = 3'd3;
   localparam logic [2:0] CLS_LF    = 3'd4;

   // lexer modes
   localparam logic [1:0] MODE_PLAIN   = 2'd0;
   localparam logic [1:0] MODE_QUOTED  = 2'd1;
   localparam logic [1:0] MODE_PENDING = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_AFTER_QUOTE = 2'd1;
   localparam logic [1:0] ERR_OPEN_QUOTE = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       command;
      logic [2:0] cls;
      logic [7:0] text_byte;
   } entry_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       field_end;
      logic       record_end;
      logic [1:0] error_code;
   } result_type;

endpackage
`default_nettype wire

### hw/rtl/csvt_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] text_byte;

   modport source (output valid, output command, output text_byte, input ready);
   modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface csvt_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] out_byte;
   logic       field_end;
   logic       record_end;
   logic [1:0] error_code;

   modport source (output valid, output byte_valid, output out_byte, output field_end,
                   output record_end, output error_code, input ready);
   modport sink   (input valid, input byte_valid, input out_byte, input field_end,
                   input record_end, input error_code, output ready);
endinterface
`default_nettype wire

### hw/rtl/csv_record_tokenizer.sv
// csv record tokenizer: usage notes
// Input channel req_ch carries one transaction per byte of CSV text
// (command 0) or an end-of-input marker (command 1). The response
// channel rsp_ch gives at most one transaction per request: a content
// byte, a field end, a field and record end, or an error code.
// A request is classified on entry and written to a small queue; unless
// a response stalls, the lexer takes one entry per cycle and loads the
// response register. A response is registered: when nothing stalls, the
// queue takes a request at the accepting edge and the lexer loads the
// response register at the next. Throughput: one request per cycle,
// sustained, as long as rsp ready stays high.
// When the receiver stalls, the response register holds and the lexer
// stops; the queue (QUEUE_DEPTH entries) absorbs requests until full,
// then req ready drops.
// Synchronous reset clears the lexer state, the queue and the response
// register; no clearing pass follows, so requests are taken right away.
// End of input flushes a pending field or reports an open quote (nothing
// if an error is latched), then returns the lexer to its reset state.
`timescale 1ns / 1ps
`default_nettype none
module csv_record_tokenizer #(
   parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   csvt_req_if.sink    req_ch,
   csvt_rsp_if.source  rsp_ch
);
   import csvt_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   csvt_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   csvt_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   csvt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

### hw/rtl/csvt_front.sv
// front end: accepts request transactions and classifies each byte
`timescale 1ns / 1ps
`default_nettype none
module csvt_front (
   csvt_req_if.sink           req_ch,
   output logic               push_valid,
   input  logic               push_ready,
   output csvt_pkg::entry_type push_data
);
   import csvt_pkg::*;

   logic [2:0] cls;

   always_comb begin
      unique case (req_ch.text_byte)
         CH_COMMA: cls = CLS_COMMA;
         CH_QUOTE: cls = CLS_QUOTE;
         CH_CR:    cls = CLS_CR;
         CH_LF:    cls = CLS_LF;
         default:  cls = CLS_OTHER;
      endcase
   end

   assign push_valid          = req_ch.valid;
   assign req_ch.ready        = push_ready;
   assign push_data.command   = req_ch.command;
   assign push_data.cls       = cls;
   assign push_data.text_byte = req_ch.text_byte;

endmodule
`default_nettype wire

### hw/rtl/csvt_fifo.sv
// short queue between the classifier and the lexer
`timescale 1ns / 1ps
`default_nettype none
module csvt_fifo #(
   parameter int DEPTH = csvt_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  csvt_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output csvt_pkg::entry_type pop_data
);
   import csvt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count did not grow on push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");
`endif

endmodule
`default_nettype wire

### hw/rtl/csvt_back.sv
// back end: lexer state machine and response output register
`timescale 1ns / 1ps
`default_nettype none
module csvt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  csvt_pkg::entry_type pop_data,
   csvt_rsp_if.source          rsp_ch
);
   import csvt_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic       acq_ff, acq_in;     // quoted field just closed
   logic       fhd_ff, fhd_in;     // field has data
   logic       rhf_ff, rhf_in;     // record has fields
   logic       cr_ff, cr_in;
   logic       err_ff, err_in;
   logic       out_valid_ff;
   result_type out_ff;
   result_type res;
   logic       res_valid;
   logic       take;
   logic       acq_eff;
   logic       is_sep;

   assign pop_ready = !out_valid_ff || rsp_ch.ready;
   assign take      = pop_valid && pop_ready;
   assign is_sep    = (pop_data.cls == CLS_COMMA) || (pop_data.cls == CLS_CR) ||
                      (pop_data.cls == CLS_LF);

   always_comb begin
      mode_in   = mode_ff;
      acq_in    = acq_ff;
      fhd_in    = fhd_ff;
      rhf_in    = rhf_ff;
      cr_in     = cr_ff;
      err_in    = err_ff;
      res       = '0;
      res_valid = 1'b0;
      acq_eff   = acq_ff;
      if (pop_data.command == CMD_END) begin
         if (!err_ff) begin
            if (mode_ff == MODE_QUOTED) begin
               res_valid      = 1'b1;
               res.error_code = ERR_OPEN_QUOTE;
            end else if (fhd_ff || rhf_ff) begin
               res_valid      = 1'b1;
               res.field_end  = 1'b1;
               res.record_end = 1'b1;
            end
         end
         mode_in = MODE_PLAIN;
         acq_in  = 1'b0;
         fhd_in  = 1'b0;
         rhf_in  = 1'b0;
         cr_in   = 1'b0;
         err_in  = 1'b0;
      end else if (err_ff) begin
         // bytes after an error are dropped until end of input
      end else if (cr_ff && (pop_data.cls == CLS_LF)) begin
         cr_in = 1'b0;
      end else begin
         cr_in = 1'b0;
         if (mode_ff == MODE_QUOTED) begin
            if (pop_data.cls == CLS_QUOTE) begin
               mode_in = MODE_PENDING;
            end else begin
               fhd_in       = 1'b1;
               res_valid    = 1'b1;
               res.byte_valid = 1'b1;
               res.out_byte = pop_data.text_byte;
            end
         end else if ((mode_ff == MODE_PENDING) && (pop_data.cls == CLS_QUOTE)) begin
            // doubled quote inside a quoted field
            mode_in        = MODE_QUOTED;
            fhd_in         = 1'b1;
            res_valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = CH_QUOTE;
         end else begin
            if (mode_ff == MODE_PENDING) begin
               acq_eff = 1'b1;
               acq_in  = 1'b1;
            end
            mode_in = MODE_PLAIN;
            if (acq_eff && !is_sep) begin
               err_in         = 1'b1;
               res_valid      = 1'b1;
               res.error_code = ERR_AFTER_QUOTE;
            end else if ((pop_data.cls == CLS_QUOTE) && !fhd_ff && !acq_eff) begin
               mode_in = MODE_QUOTED;
            end else if (pop_data.cls == CLS_COMMA) begin
               fhd_in        = 1'b0;
               acq_in        = 1'b0;
               rhf_in        = 1'b1;
               res_valid     = 1'b1;
               res.field_end = 1'b1;
            end else if ((pop_data.cls == CLS_CR) || (pop_data.cls == CLS_LF)) begin
               fhd_in         = 1'b0;
               acq_in         = 1'b0;
               rhf_in         = 1'b0;
               cr_in          = (pop_data.cls == CLS_CR);
               res_valid      = 1'b1;
               res.field_end  = 1'b1;
               res.record_end = 1'b1;
            end else begin
               fhd_in         = 1'b1;
               res_valid      = 1'b1;
               res.byte_valid = 1'b1;
               res.out_byte   = pop_data.text_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         acq_ff       <= 1'b0;
         fhd_ff       <= 1'b0;
         rhf_ff       <= 1'b0;
         cr_ff        <= 1'b0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            mode_ff <= mode_in;
            acq_ff  <= acq_in;
            fhd_ff  <= fhd_in;
            rhf_ff  <= rhf_in;
            cr_ff   <= cr_in;
            err_ff  <= err_in;
         end
         if (take && res_valid) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.byte_valid = out_ff.byte_valid;
   assign rsp_ch.out_byte   = out_ff.out_byte;
   assign rsp_ch.field_end  = out_ff.field_end;
   assign rsp_ch.record_end = out_ff.record_end;
   assign rsp_ch.error_code = out_ff.error_code;

`ifndef SYNTHESIS
   a_rend_with_fend: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.record_end) |-> out_ff.field_end)
      else $error("record end without field end");
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.error_code != ERR_NONE)) |->
      (!out_ff.byte_valid && !out_ff.field_end && (out_ff.out_byte == 8'h00)))
      else $error("error transaction carries other fields");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled response changed");
   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      (take && err_ff && (pop_data.command == CMD_BYTE)) |-> !res_valid)
      else $error("result produced after error");
`endif

endmodule
`default_nettype wire

### test/tb_csv_record_tokenizer.sv
// self-checking testbench for the csv record tokenizer
`timescale 1ns / 1ps
module tb_csv_record_tokenizer;
   import csvt_pkg::*;

   typedef enum logic [1:0] {CHK_MODEL, CHK_RESULT, CHK_SILENT} chk_kind_type;

   typedef struct {
      logic         command;
      logic [7:0]   text_byte;
      chk_kind_type chk;
      result_type   pin;
   } csv_item_type;

   localparam result_type NO_RSP = '0;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_AT = 500;
   localparam int HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT = 1000;
   localparam int MAX_REPORTS = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csvt_req_if req_ch ();
   csvt_rsp_if rsp_ch ();

   csv_record_tokenizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tokenizer state as predicted
   logic [1:0] tk_mode;
   bit tk_closed, tk_data, tk_fields, tk_cr, tk_err;

   result_type   pending_tokens[$];
   csv_item_type csv_text_q[$];
   csv_item_type directed_rows[$];

   // what the sender presents alongside the current transaction
   chk_kind_type drv_chk = CHK_MODEL;
   result_type   drv_pin = '0;

   int items_sent = 0;
   int random_sent = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int ends_sent = 0;
   int n_bytes = 0, n_fields = 0, n_records = 0, n_errors = 0;
   bit holding = 1'b0;
   bit hold_done = 1'b0;

   function automatic void clear_tokenizer();
      tk_mode = MODE_PLAIN;
      tk_closed = 1'b0;
      tk_data = 1'b0;
      tk_fields = 1'b0;
      tk_cr = 1'b0;
      tk_err = 1'b0;
   endfunction

   // returns 1 when the transaction yields a token
   function automatic bit tokenize_step(input logic cmd, input logic [7:0] b,
                                        output result_type r);
      bit sep;
      bit found;
      r = '0;
      found = 1'b0;
      if (cmd == CMD_END) begin
         if (!tk_err) begin
            if (tk_mode == MODE_QUOTED) begin
               r.error_code = ERR_OPEN_QUOTE;
               found = 1'b1;
            end else if (tk_data || tk_fields) begin
               r.field_end = 1'b1;
               r.record_end = 1'b1;
               found = 1'b1;
            end
         end
         clear_tokenizer();
         return found;
      end
      if (tk_err) return 1'b0;
      if (tk_cr) begin
         tk_cr = 1'b0;
         if (b == CH_LF) return 1'b0;
      end
      if (tk_mode == MODE_QUOTED) begin
         if (b == CH_QUOTE) begin
            tk_mode = MODE_PENDING;
            return 1'b0;
         end
         tk_data = 1'b1;
         r.byte_valid = 1'b1;
         r.out_byte = b;
         return 1'b1;
      end
      if (tk_mode == MODE_PENDING) begin
         // second quote of a pair is a literal quote
         if (b == CH_QUOTE) begin
            tk_mode = MODE_QUOTED;
            tk_data = 1'b1;
            r.byte_valid = 1'b1;
            r.out_byte = CH_QUOTE;
            return 1'b1;
         end
         tk_closed = 1'b1;
      end
      tk_mode = MODE_PLAIN;
      sep = (b == CH_COMMA) || (b == CH_CR) || (b == CH_LF);
      if (tk_closed && !sep) begin
         tk_err = 1'b1;
         r.error_code = ERR_AFTER_QUOTE;
         return 1'b1;
      end
      if (b == CH_QUOTE && !tk_data && !tk_closed) begin
         tk_mode = MODE_QUOTED;
         return 1'b0;
      end
      if (b == CH_COMMA) begin
         tk_data = 1'b0;
         tk_closed = 1'b0;
         tk_fields = 1'b1;
         r.field_end = 1'b1;
         return 1'b1;
      end
      if (b == CH_CR || b == CH_LF) begin
         tk_data = 1'b0;
         tk_closed = 1'b0;
         tk_fields = 1'b0;
         tk_cr = (b == CH_CR);
         r.field_end = 1'b1;
         r.record_end = 1'b1;
         return 1'b1;
      end
      tk_data = 1'b1;
      r.byte_valid = 1'b1;
      r.out_byte = b;
      return 1'b1;
   endfunction

   function automatic result_type rs(input bit bv, input logic [7:0] ob, input bit fe,
                                     input bit re, input logic [1:0] err);
      result_type r;
      r.byte_valid = bv;
      r.out_byte = ob;
      r.field_end = fe;
      r.record_end = re;
      r.error_code = err;
      return r;
   endfunction

   task automatic add_row(input logic cmd, input logic [7:0] b, input chk_kind_type chk,
                          input result_type pin);
      csv_item_type it;
      it.command = cmd;
      it.text_byte = b;
      it.chk = chk;
      it.pin = pin;
      directed_rows.insert(directed_rows.size(), it);
   endtask

   task automatic push_byte(input logic [7:0] b);
      csv_item_type it;
      it.command = CMD_BYTE;
      it.text_byte = b;
      it.chk = CHK_MODEL;
      it.pin = NO_RSP;
      csv_text_q.insert(csv_text_q.size(), it);
   endtask

   task automatic push_end();
      csv_item_type it;
      it.command = CMD_END;
      it.text_byte = 8'($urandom_range(0, 255));
      it.chk = CHK_MODEL;
      it.pin = NO_RSP;
      csv_text_q.insert(csv_text_q.size(), it);
   endtask

   function automatic logic [7:0] bare_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
      return b;
   endfunction

   // quoted body with doubled quotes and embedded separators
   task automatic push_quoted_body();
      int len;
      int r;
      logic [7:0] b;
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            push_byte(CH_QUOTE);
            push_byte(CH_QUOTE);
         end else if (r < 24) begin
            case ($urandom_range(0, 2))
               0: push_byte(CH_COMMA);
               1: push_byte(CH_CR);
               default: push_byte(CH_LF);
            endcase
         end else begin
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            if (b == CH_QUOTE) push_byte(CH_QUOTE);
         end
      end
   endtask

   task automatic gen_record();
      int nf;
      int len;
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) push_byte(CH_COMMA);
         if ($urandom_range(0, 99) < 35) begin
            push_byte(CH_QUOTE);
            push_quoted_body();
            push_byte(CH_QUOTE);
         end else begin
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) push_byte(bare_byte());
         end
      end
      case ($urandom_range(0, 3))
         0: push_byte(CH_CR);
         1: push_byte(CH_LF);
         2: begin
            push_byte(CH_CR);
            push_byte(CH_LF);
         end
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0) push_end();
   endtask

   task automatic gen_broken();
      logic [7:0] b;
      push_byte(CH_QUOTE);
      push_quoted_body();
      if ($urandom_range(0, 1) == 0) begin
         // text straight after the closing quote
         push_byte(CH_QUOTE);
         b = bare_byte();
         push_byte(b);
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      end
      push_end();
   endtask

   task automatic gen_noise();
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) push_end();
   endtask

   function automatic bit quiet_phase();
      return ((items_sent / 150) % 3) == 1;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic send(input csv_item_type it);
      int g;
      g = 0;
      if (!holding && !quiet_phase() && $urandom_range(0, 99) < 40) g = idle_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= it.command;
      req_ch.text_byte <= it.text_byte;
      drv_chk = it.chk;
      drv_pin = it.pin;
      do @(posedge clock);
      while (!req_ch.ready);
      items_sent++;
      if (it.command == CMD_END) ends_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // request and response monitor
   always @(posedge clock) begin
      result_type predicted;
      result_type want;
      result_type got;
      bit has_token;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            has_token = tokenize_step(req_ch.command, req_ch.text_byte, predicted);
            case (drv_chk)
               CHK_MODEL:  if (has_token) pending_tokens.insert(pending_tokens.size(),
                                                                predicted);
               CHK_RESULT: pending_tokens.insert(pending_tokens.size(), drv_pin);
               default:    ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.byte_valid = rsp_ch.byte_valid;
            got.out_byte = rsp_ch.out_byte;
            got.field_end = rsp_ch.field_end;
            got.record_end = rsp_ch.record_end;
            got.error_code = rsp_ch.error_code;
            if (got.byte_valid) n_bytes++;
            if (got.field_end) n_fields++;
            if (got.record_end) n_records++;
            if (got.error_code != ERR_NONE) n_errors++;
            if (pending_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected token %h", got));
            end else begin
               want = pending_tokens.pop_front();
               if (got.byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid %b, expected %b",
                                            got.byte_valid, want.byte_valid));
               if (got.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            got.out_byte, want.out_byte));
               if (got.field_end !== want.field_end)
                  report_mismatch($sformatf("field_end %b, expected %b",
                                            got.field_end, want.field_end));
               if (got.record_end !== want.record_end)
                  report_mismatch($sformatf("record_end %b, expected %b",
                                            got.record_end, want.record_end));
               if (got.error_code !== want.error_code)
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            got.error_code, want.error_code));
            end
         end
      end
   end

   // receiver, with one long hold-off so the input queue fills up
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            holding = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            holding = 1'b0;
            rsp_ch.ready <= 1'b1;
            if (!quiet_phase() && $urandom_range(0, 99) < 25) stall_left = idle_len();
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("csv_record_tokenizer regression: fail");
      $finish;
   end

   initial begin : stimulus
      int r;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_BYTE;
      req_ch.text_byte = 8'h00;
      clear_tokenizer();

      // plain field, extremes of the byte range, cr-lf pair
      add_row(CMD_BYTE, 8'h61,    CHK_RESULT, rs(1'b1, 8'h61, 1'b0, 1'b0, ERR_NONE));
      add_row(CMD_BYTE, CH_COMMA, CHK_RESULT, rs(1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE));
      add_row(CMD_BYTE, 8'hFF,    CHK_RESULT, rs(1'b1, 8'hFF, 1'b0, 1'b0, ERR_NONE));
      add_row(CMD_BYTE, 8'h00,    CHK_RESULT, rs(1'b1, 8'h00, 1'b0, 1'b0, ERR_NONE));
      add_row(CMD_BYTE, CH_CR,    CHK_RESULT, rs(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE));
      add_row(CMD_BYTE, CH_LF,    CHK_SILENT, NO_RSP);
      // quoted field with an embedded comma and a doubled quote
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_BYTE, CH_COMMA, CHK_MODEL, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_MODEL, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_MODEL, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_MODEL, NO_RSP);
      add_row(CMD_BYTE, CH_CR,    CHK_MODEL, NO_RSP);
      // cr not followed by lf, then a quote inside a bare field
      add_row(CMD_BYTE, 8'h62,    CHK_MODEL, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_MODEL, NO_RSP);
      add_row(CMD_END,  8'h00,    CHK_RESULT, rs(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE));
      // text after a closing quote, bytes ignored, end with the error latched
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_BYTE, 8'h7A,    CHK_RESULT,
              rs(1'b0, 8'h00, 1'b0, 1'b0, ERR_AFTER_QUOTE));
      add_row(CMD_BYTE, 8'h71,    CHK_SILENT, NO_RSP);
      add_row(CMD_END,  8'hFF,    CHK_SILENT, NO_RSP);
      // end inside an open quote
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_END,  8'h00,    CHK_RESULT,
              rs(1'b0, 8'h00, 1'b0, 1'b0, ERR_OPEN_QUOTE));
      // lone empty quoted field is not flushed at end
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_BYTE, CH_QUOTE, CHK_SILENT, NO_RSP);
      add_row(CMD_END,  8'h00,    CHK_SILENT, NO_RSP);
      // trailing empty field is flushed
      add_row(CMD_BYTE, CH_COMMA, CHK_MODEL, NO_RSP);
      add_row(CMD_END,  8'h00,    CHK_RESULT, rs(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE));

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send(directed_rows[i]);

      while (random_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 80) gen_record();
         else if (r < 90) gen_broken();
         else gen_noise();
         while (csv_text_q.size() > 0) begin
            send(csv_text_q.pop_front());
            random_sent++;
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d requests, %0d of them end-of-input, with one long response hold-off",
               items_sent, ends_sent);
      $display("checked %0d content bytes, %0d field ends, %0d record ends, %0d errors",
               n_bytes, n_fields, n_records, n_errors);
      if (mismatches == 0)
         $display("csv_record_tokenizer regression: pass");
      else
         $display("csv_record_tokenizer regression: fail");
      $finish;
   end

endmodule
